/* rtl/core/caldate_pkg.sv */
// Shared types, constants and helper functions for the calendar date calculator.
package caldate_pkg;

  typedef logic [13:0]        year_t;
  typedef logic [3:0]         month_t;
  typedef logic [4:0]         day_t;
  typedef logic signed [22:0] days_t;
  typedef logic [21:0]        dnum_t;
  typedef logic [8:0]         doy_t;
  typedef logic [7:0]         quot_t;

  localparam year_t  YEAR_MIN        = 14'd1;
  localparam year_t  YEAR_MAX        = 14'd9999;
  localparam month_t MONTH_FEB       = 4'd2;
  localparam month_t MONTHS_PER_YEAR = 4'd12;
  // Index of January when months are counted from March.
  localparam month_t MP_JAN          = 4'd10;

  // Day numbers of 0001-01-01 and 9999-12-31, counted from March 1 of year 0.
  localparam dnum_t DNUM_MIN = 22'd306;
  localparam dnum_t DNUM_MAX = 22'd3652364;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [12:0] DIV25_MUL     = 13'd5243;
  localparam int unsigned DIV25_SHIFT   = 17;
  // floor(2^32 / 365.2425), used to estimate the year of a day number.
  localparam logic [23:0] YEAR_RECIP    = 24'd11759221;

  // Exact x / 25 for any 12-bit x, by reciprocal multiplication.
  function automatic quot_t div25(input logic [11:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'(DIV25_MUL);
    return prod[24:DIV25_SHIFT];
  endfunction

  // First day of each month within a year that starts in March.
  function automatic doy_t march_start(input month_t mp);
    doy_t res;
    unique case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Day number of March 1 of a March-based year, given yr/100 and yr/400.
  function automatic dnum_t year_days(input year_t yr, input quot_t q100, input quot_t q400);
    logic [22:0] acc;
    acc = 23'(yr) * 23'(DAYS_PER_YEAR) + 23'(yr[13:2]) - 23'(q100) + 23'(q400);
    return acc[21:0];
  endfunction

endpackage

/* rtl/core/caldate_if.sv */
// Request and response channel interfaces of the calendar date calculator.
interface caldate_req_if;
  logic                  valid;
  logic                  ready;
  caldate_pkg::year_t    a_year;
  caldate_pkg::month_t   a_month;
  caldate_pkg::day_t     a_day;
  caldate_pkg::year_t    b_year;
  caldate_pkg::month_t   b_month;
  caldate_pkg::day_t     b_day;
  caldate_pkg::days_t    offset_days;

  modport source (
    output valid, a_year, a_month, a_day, b_year, b_month, b_day, offset_days,
    input  ready
  );
  modport sink (
    input  valid, a_year, a_month, a_day, b_year, b_month, b_day, offset_days,
    output ready
  );
endinterface

interface caldate_rsp_if;
  logic                  valid;
  logic                  ready;
  caldate_pkg::year_t    sum_year;
  caldate_pkg::month_t   sum_month;
  caldate_pkg::day_t     sum_day;
  caldate_pkg::days_t    diff_days;
  logic                  a_earlier;
  logic                  dates_equal;
  logic                  a_valid;
  logic                  b_valid;
  logic                  sum_error;

  modport source (
    output valid, sum_year, sum_month, sum_day, diff_days, a_earlier, dates_equal,
           a_valid, b_valid, sum_error,
    input  ready
  );
  modport sink (
    input  valid, sum_year, sum_month, sum_day, diff_days, a_earlier, dates_equal,
           a_valid, b_valid, sum_error,
    output ready
  );
endinterface

/* rtl/core/calendar_date_calculator_top.sv */
// Top level of the calendar date calculator: date sum, difference and compare.
//
// Each request on req_i carries two Gregorian dates A and B and a signed day
// offset. The response on rsp_o gives A plus the offset, the signed day count
// A minus B, the ordering of A against B and a validity flag for each date.
// Both channels use valid/ready; a request is taken when both are high.
// The work is an eight-stage pipeline, and one request can be taken every
// cycle while the receiver keeps rsp_o.ready high. The depth
// is set by the two constant multiplications of the day-number conversion
// and the four stages of the inverse conversion, each with its own register.
// Every stage advances when it is empty or the stage after it advances, so
// while the receiver holds ready low the pipeline keeps filling its empty
// stages and only then lowers req_i.ready; no response is dropped or repeated.
// Reset clears all stage valid flags; the pipeline is empty and ready at once.
// A sum outside 0001-01-01 to 9999-12-31, or an invalid date A, raises
// sum_error and zeros the sum date; the difference is zero unless both dates
// are valid.
module calendar_date_calculator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  caldate_req_if.sink   req_i,
  caldate_rsp_if.source rsp_o
);
  import caldate_pkg::*;

  typedef struct packed {
    year_t  y;
    month_t m;
    day_t   d;
    year_t  yy;
    quot_t  q100;
    quot_t  q400;
    quot_t  qy;
  } date_pre_t;

  typedef struct packed {
    logic  err;
    days_t diff;
    logic  a_earlier;
    logic  dates_equal;
    logic  a_valid;
    logic  b_valid;
  } side_t;

  function automatic date_pre_t pre_date(input year_t y, input month_t m, input day_t d);
    date_pre_t p;
    p.y    = y;
    p.m    = m;
    p.d    = d;
    // January and February belong to the previous March-based year.
    p.yy   = (m <= MONTH_FEB) ? y - 14'd1 : y;
    p.q100 = div25(p.yy[13:2]);
    p.q400 = div25({2'b00, p.yy[13:4]});
    p.qy   = div25(y[13:2]);
    return p;
  endfunction

  function automatic day_t month_days(input month_t m, input logic leap);
    day_t res;
    unique case (m)
      4'd2:                      res = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   res = 5'd30;
      default:                   res = 5'd31;
    endcase
    return res;
  endfunction

  function automatic logic date_ok(input date_pre_t p);
    logic div100;
    logic leap;
    day_t dim;
    // For a year divisible by 4, year/4 divisible by 25 means a century year.
    div100 = ((12'(p.qy) * 12'd25) == p.y[13:2]);
    leap   = (p.y[1:0] == 2'b00) && (!div100 || (p.y[3:2] == 2'b00));
    dim    = month_days(p.m, leap);
    return (p.y >= YEAR_MIN) && (p.y <= YEAR_MAX) && (p.m >= 4'd1) &&
           (p.m <= MONTHS_PER_YEAR) && (p.d >= 5'd1) && (p.d <= dim);
  endfunction

  function automatic dnum_t date_num(input date_pre_t p);
    month_t mp;
    doy_t   doy;
    mp  = (p.m > MONTH_FEB) ? p.m - 4'd3 : p.m + 4'd9;
    doy = march_start(mp) + 9'(p.d) - 9'd1;
    return year_days(p.yy, p.q100, p.q400) + 22'(doy);
  endfunction

  logic [7:0]        vld_q;
  logic [7:0]        vld_d;
  logic [7:0]        en;

  date_pre_t         p1_a_q;
  date_pre_t         p1_b_q;
  logic              p1_earlier_q;
  logic              p1_equal_q;
  days_t             p1_off_q;

  logic              p2_av_q;
  logic              p2_bv_q;
  dnum_t             p2_dna_q;
  dnum_t             p2_dnb_q;
  logic              p2_earlier_q;
  logic              p2_equal_q;
  days_t             p2_off_q;

  logic signed [23:0] sum_num;
  side_t             p3_side_d;
  side_t             p3_side_q;
  dnum_t             p3_n_q;
  side_t             side_q [4];

  year_t             fd_year;
  doy_t              fd_doy;

  month_t            out_mp;
  month_t            out_month;
  year_t             out_year;
  doy_t              out_day_full;

  year_t             sum_year_q;
  month_t            sum_month_q;
  day_t              sum_day_q;
  days_t             diff_days_q;
  logic              a_earlier_q;
  logic              dates_equal_q;
  logic              a_valid_q;
  logic              b_valid_q;
  logic              sum_error_q;

  // A stage moves on when it is empty or the stage after it moves on.
  assign en[7] = ~vld_q[7] | rsp_o.ready;
  assign en[6] = ~vld_q[6] | en[7];
  assign en[5] = ~vld_q[5] | en[6];
  assign en[4] = ~vld_q[4] | en[5];
  assign en[3] = ~vld_q[3] | en[4];
  assign en[2] = ~vld_q[2] | en[3];
  assign en[1] = ~vld_q[1] | en[2];
  assign en[0] = ~vld_q[0] | en[1];

  assign vld_d = (en & {vld_q[6:0], req_i.valid}) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign req_i.ready = en[0];

  always_comb begin
    sum_num            = $signed({2'b00, p2_dna_q}) + 24'(p2_off_q);
    p3_side_d.err      = !p2_av_q || (sum_num < $signed({2'b00, DNUM_MIN})) ||
                         (sum_num > $signed({2'b00, DNUM_MAX}));
    p3_side_d.diff     = (p2_av_q && p2_bv_q) ?
                         days_t'({1'b0, p2_dna_q} - {1'b0, p2_dnb_q}) : '0;
    p3_side_d.a_earlier   = p2_earlier_q;
    p3_side_d.dates_equal = p2_equal_q;
    p3_side_d.a_valid     = p2_av_q;
    p3_side_d.b_valid     = p2_bv_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_a_q       <= pre_date(req_i.a_year, req_i.a_month, req_i.a_day);
      p1_b_q       <= pre_date(req_i.b_year, req_i.b_month, req_i.b_day);
      p1_earlier_q <= {req_i.a_year, req_i.a_month, req_i.a_day} <
                      {req_i.b_year, req_i.b_month, req_i.b_day};
      p1_equal_q   <= {req_i.a_year, req_i.a_month, req_i.a_day} ==
                      {req_i.b_year, req_i.b_month, req_i.b_day};
      p1_off_q     <= req_i.offset_days;
    end
    if (en[1]) begin
      p2_av_q      <= date_ok(p1_a_q);
      p2_bv_q      <= date_ok(p1_b_q);
      p2_dna_q     <= date_num(p1_a_q);
      p2_dnb_q     <= date_num(p1_b_q);
      p2_earlier_q <= p1_earlier_q;
      p2_equal_q   <= p1_equal_q;
      p2_off_q     <= p1_off_q;
    end
    if (en[2]) begin
      p3_side_q <= p3_side_d;
      p3_n_q    <= sum_num[21:0];
    end
    if (en[3]) begin
      side_q[0] <= p3_side_q;
    end
    if (en[4]) begin
      side_q[1] <= side_q[0];
    end
    if (en[5]) begin
      side_q[2] <= side_q[1];
    end
    if (en[6]) begin
      side_q[3] <= side_q[2];
    end
  end

  caldate_from_days u_from_days (
    .clk_i  (clk_i),
    .en_i   (en[6:3]),
    .n_i    (p3_n_q),
    .year_o (fd_year),
    .doy_o  (fd_doy)
  );

  // Month within the March-based year: the last month start not past the day.
  always_comb begin
    out_mp = '0;
    for (int k = 1; k < 12; k++) begin
      if (fd_doy >= march_start(4'(k))) begin
        out_mp = 4'(k);
      end
    end
    out_month    = (out_mp < MP_JAN) ? out_mp + 4'd3 : out_mp - 4'd9;
    out_year     = fd_year + ((out_mp >= MP_JAN) ? 14'd1 : 14'd0);
    out_day_full = fd_doy - march_start(out_mp) + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      sum_year_q    <= side_q[3].err ? '0 : out_year;
      sum_month_q   <= side_q[3].err ? '0 : out_month;
      sum_day_q     <= side_q[3].err ? '0 : out_day_full[4:0];
      diff_days_q   <= side_q[3].diff;
      a_earlier_q   <= side_q[3].a_earlier;
      dates_equal_q <= side_q[3].dates_equal;
      a_valid_q     <= side_q[3].a_valid;
      b_valid_q     <= side_q[3].b_valid;
      sum_error_q   <= side_q[3].err;
    end
  end

  assign rsp_o.valid       = vld_q[7];
  assign rsp_o.sum_year    = sum_year_q;
  assign rsp_o.sum_month   = sum_month_q;
  assign rsp_o.sum_day     = sum_day_q;
  assign rsp_o.diff_days   = diff_days_q;
  assign rsp_o.a_earlier   = a_earlier_q;
  assign rsp_o.dates_equal = dates_equal_q;
  assign rsp_o.a_valid     = a_valid_q;
  assign rsp_o.b_valid     = b_valid_q;
  assign rsp_o.sum_error   = sum_error_q;

endmodule

/* rtl/core/caldate_from_days.sv */
// Four-stage conversion of a day number into a March-based year and day of year.
module caldate_from_days (
  input  logic                clk_i,
  input  logic [3:0]          en_i,
  input  caldate_pkg::dnum_t  n_i,
  output caldate_pkg::year_t  year_o,
  output caldate_pkg::doy_t   doy_o
);
  import caldate_pkg::*;

  logic [45:0] est_prod;
  year_t       est_e_q;
  dnum_t       est_n_q;
  year_t       est_em;

  year_t       qt_e_q;
  dnum_t       qt_n_q;
  quot_t       qt_e100_q;
  quot_t       qt_e400_q;
  quot_t       qt_m100_q;
  quot_t       qt_m400_q;

  year_t       st_yr_q;
  dnum_t       st_n_q;
  dnum_t       st_e_q;
  dnum_t       st_m_q;

  logic        take_e;
  dnum_t       rem;
  year_t       year_q;
  doy_t        doy_q;

  // The estimate is the true year or one below it, so the candidate is
  // the estimate plus one, checked against its March 1 later on.
  assign est_prod = 46'(n_i) * 46'(YEAR_RECIP);
  assign est_em   = est_e_q - 14'd1;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      est_e_q <= est_prod[45:32] + 14'd1;
      est_n_q <= n_i;
    end
    if (en_i[1]) begin
      qt_e_q    <= est_e_q;
      qt_n_q    <= est_n_q;
      qt_e100_q <= div25(est_e_q[13:2]);
      qt_e400_q <= div25({2'b00, est_e_q[13:4]});
      qt_m100_q <= div25(est_em[13:2]);
      qt_m400_q <= div25({2'b00, est_em[13:4]});
    end
    if (en_i[2]) begin
      st_yr_q <= qt_e_q;
      st_n_q  <= qt_n_q;
      st_e_q  <= year_days(qt_e_q, qt_e100_q, qt_e400_q);
      st_m_q  <= year_days(qt_e_q - 14'd1, qt_m100_q, qt_m400_q);
    end
    if (en_i[3]) begin
      year_q <= take_e ? st_yr_q : st_yr_q - 14'd1;
      doy_q  <= rem[8:0];
    end
  end

  assign take_e = (st_e_q <= st_n_q);
  assign rem    = st_n_q - (take_e ? st_e_q : st_m_q);

  assign year_o = year_q;
  assign doy_o  = doy_q;

endmodule

/* verif/caldate_checker.sv */
// Checker for the calendar date calculator: predicts each response and compares it.
module caldate_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  caldate_req_if      req_i,
  caldate_rsp_if      rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import caldate_pkg::*;

  localparam int DAYS_PER_400_YEARS = 146097;

  typedef struct packed {
    year_t  sum_year;
    month_t sum_month;
    day_t   sum_day;
    days_t  diff_days;
    logic   a_earlier;
    logic   dates_equal;
    logic   a_valid;
    logic   b_valid;
    logic   sum_error;
  } caldate_result_t;

  typedef struct packed {
    year_t  y;
    month_t m;
    day_t   d;
  } civil_date_t;

  caldate_result_t expected_q[$];
  int unsigned     mismatches  = 0;
  int unsigned     outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;

  function automatic bit leap_year(int y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int month_days(int y, int m);
    if (m < 1 || m > int'(MONTHS_PER_YEAR)) return 0;
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit real_date(int y, int m, int d);
    return y >= int'(YEAR_MIN) && y <= int'(YEAR_MAX) && d >= 1 && d <= month_days(y, m);
  endfunction

  // Days since March 1 of year 0; the year is counted from March so that
  // the leap day is the last day of the year.
  function automatic int serial_day(int y, int m, int d);
    int yy, cyc, yic, mi, doy;
    yy  = (m <= 2) ? y - 1 : y;
    cyc = yy / 400;
    yic = yy - cyc * 400;
    mi  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mi + 2) / 5 + d - 1;
    return cyc * DAYS_PER_400_YEARS + yic * 365 + yic / 4 - yic / 100 + doy;
  endfunction

  function automatic civil_date_t date_of_serial(int z);
    civil_date_t c;
    int cyc, doc, yic, doy, mp, mm;
    cyc = z / DAYS_PER_400_YEARS;
    doc = z - cyc * DAYS_PER_400_YEARS;
    yic = (doc - doc / 1460 + doc / 36524 - doc / 146096) / 365;
    doy = doc - (365 * yic + yic / 4 - yic / 100);
    mp  = (5 * doy + 2) / 153;
    mm  = (mp < 10) ? mp + 3 : mp - 9;
    c.d = day_t'(doy - (153 * mp + 2) / 5 + 1);
    c.m = month_t'(mm);
    c.y = year_t'(yic + cyc * 400 + ((mm <= 2) ? 1 : 0));
    return c;
  endfunction

  function automatic caldate_result_t predict_result(
    year_t ay, month_t am, day_t ad, year_t by, month_t bm, day_t bd, days_t off
  );
    caldate_result_t r;
    civil_date_t     c;
    int              sa, target;
    r             = '0;
    r.a_valid     = real_date(ay, am, ad);
    r.b_valid     = real_date(by, bm, bd);
    // Ordering always looks at the raw fields, valid or not.
    r.a_earlier   = {ay, am, ad} < {by, bm, bd};
    r.dates_equal = {ay, am, ad} == {by, bm, bd};
    r.sum_error   = 1'b1;
    if (r.a_valid) begin
      sa     = serial_day(ay, am, ad);
      target = sa + int'(off);
      if (target >= serial_day(int'(YEAR_MIN), 1, 1) &&
          target <= serial_day(int'(YEAR_MAX), int'(MONTHS_PER_YEAR), 31)) begin
        c           = date_of_serial(target);
        r.sum_year  = c.y;
        r.sum_month = c.m;
        r.sum_day   = c.d;
        r.sum_error = 1'b0;
      end
      if (r.b_valid) r.diff_days = days_t'(sa - serial_day(by, bm, bd));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] caldate mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [22:0] got, input logic [22:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic compare_result(input caldate_result_t want);
    check_field("sum_year",    23'(rsp_i.sum_year),    23'(want.sum_year));
    check_field("sum_month",   23'(rsp_i.sum_month),   23'(want.sum_month));
    check_field("sum_day",     23'(rsp_i.sum_day),     23'(want.sum_day));
    check_field("diff_days",   23'(rsp_i.diff_days),   23'(want.diff_days));
    check_field("a_earlier",   23'(rsp_i.a_earlier),   23'(want.a_earlier));
    check_field("dates_equal", 23'(rsp_i.dates_equal), 23'(want.dates_equal));
    check_field("a_valid",     23'(rsp_i.a_valid),     23'(want.a_valid));
    check_field("b_valid",     23'(rsp_i.b_valid),     23'(want.b_valid));
    check_field("sum_error",   23'(rsp_i.sum_error),   23'(want.sum_error));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (expected_q.size() == 0) report_mismatch("response with no request outstanding");
        else compare_result(expected_q.pop_front());
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        expected_q.push_back(predict_result(req_i.a_year, req_i.a_month, req_i.a_day,
                                            req_i.b_year, req_i.b_month, req_i.b_day,
                                            req_i.offset_days));
      end
      outstanding = expected_q.size();
    end
  end

endmodule

/* verif/calendar_date_calculator_top_tb.sv */
// Testbench top of the calendar date calculator: stimulus, response stalls and verdict.
module calendar_date_calculator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import caldate_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned outstanding;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  caldate_req_if req ();
  caldate_rsp_if rsp ();

  calendar_date_calculator_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  caldate_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .rsp_i            (rsp),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always #1 clk_i = ~clk_i;

  // Holds valid low for a drawn gap, then presents one request until it is taken.
  task automatic issue_request(
    input year_t ay, input month_t am, input day_t ad,
    input year_t by, input month_t bm, input day_t bd, input days_t off
  );
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.a_year      <= ay;
    req.a_month     <= am;
    req.a_day       <= ad;
    req.b_year      <= by;
    req.b_month     <= bm;
    req.b_day       <= bd;
    req.offset_days <= off;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
  endtask

  // Receiver: stalls a drawn number of cycles before each response.
  initial begin
    int gap;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
      while (rsp.valid !== 1'b1) @(posedge clk_i);
    end
  end

  initial begin
    #1000000;
    $display("calendar_date_calculator_top_tb NOT OK");
    $finish;
  end

  initial begin
    year_t  ay, by;
    month_t am, bm;
    day_t   ad, bd;
    days_t  off;
    int     pick;
    rst_ni          <= 1'b0;
    req.valid       <= 1'b0;
    req.a_year      <= '0;
    req.a_month     <= '0;
    req.a_day       <= '0;
    req.b_year      <= '0;
    req.b_month     <= '0;
    req.b_day       <= '0;
    req.offset_days <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: leap days, carries and borrows, range ends, invalid fields.
    issue_request(2024, 2, 29, 2024, 2, 28, 1);
    issue_request(1, 1, 1, 1, 1, 1, -1);
    issue_request(9999, 12, 31, 1, 1, 1, 1);
    issue_request(1, 1, 1, 9999, 12, 31, 3652058);
    issue_request(9999, 12, 31, 9999, 12, 30, -3652058);
    issue_request(5000, 6, 15, 5000, 6, 15, -4194304);
    issue_request(5000, 6, 15, 1, 1, 1, 4194303);
    issue_request(2023, 12, 31, 2024, 1, 1, 1);
    issue_request(2023, 3, 1, 2023, 2, 28, -1);
    issue_request(1900, 2, 29, 1900, 2, 28, 0);
    issue_request(2000, 2, 29, 2100, 2, 29, 365);
    issue_request(0, 1, 1, 1, 1, 1, 5);
    issue_request(10000, 1, 1, 9999, 12, 31, -1);
    issue_request(16383, 15, 31, 0, 0, 0, 0);
    issue_request(2023, 0, 10, 2023, 13, 10, 3);
    issue_request(2023, 4, 31, 2023, 4, 0, 1);
    issue_request(2023, 5, 31, 2023, 5, 31, 30);
    issue_request(1600, 2, 29, 1700, 2, 29, -1);
    issue_request(2023, 15, 1, 2023, 14, 31, 0);
    issue_request(2023, 1, 1, 2023, 1, 2, 0);
    issue_request(2023, 12, 31, 2022, 12, 31, -365);
    issue_request(2, 3, 1, 9998, 2, 28, -425);

    for (int n = 0; n < 1350; n++) begin
      if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // Raw field noise, mostly invalid dates.
        ay  = year_t'($urandom);
        am  = month_t'($urandom);
        ad  = day_t'($urandom);
        by  = year_t'($urandom);
        bm  = month_t'($urandom);
        bd  = day_t'($urandom);
        off = days_t'($urandom);
      end else begin
        if ($urandom_range(0, 9) == 0)
          ay = year_t'($urandom_range(0, 1) ? $urandom_range(1, 3)
                                             : $urandom_range(9997, 9999));
        else
          ay = year_t'($urandom_range(1, 9999));
        am = month_t'($urandom_range(1, 12));
        ad = day_t'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 31)
                                                 : $urandom_range(1, 28));
        if (pick < 25) begin
          by = ay;
          bm = am;
          bd = ad;
        end else if (pick < 35) begin
          by = ay;
          bm = am;
          bd = day_t'($urandom_range(1, 28));
        end else begin
          by = year_t'($urandom_range(1, 9999));
          bm = month_t'($urandom_range(1, 12));
          bd = day_t'($urandom_range(1, 28));
        end
        case ($urandom_range(0, 4))
          0:       off = days_t'(int'($urandom_range(0, 80)) - 40);
          1:       off = days_t'(int'($urandom_range(0, 3000)) - 1500);
          2:       off = days_t'(int'($urandom_range(0, 800000)) - 400000);
          3:       off = days_t'($urandom);
          default: off = days_t'(int'($urandom_range(0, 7304116)) - 3652058);
        endcase
      end
      issue_request(ay, am, ad, by, bm, bd, off);
    end
    req.valid <= 1'b0;

    // Let the checker record the last request before waiting for the drain.
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("calendar_date_calculator_top_tb OK");
    end else begin
      $display("calendar_date_calculator_top_tb NOT OK");
    end
    $finish;
  end

endmodule
